// ===== rtl/tlbpt_pkg.sv =====
package tlbpt_pkg;

    // Address split.
    localparam int VA_W        = 16;
    localparam int PAGE_BITS   = 8;
    localparam int PAGE_W      = 8;
    localparam int OFF_W       = PAGE_BITS;
    localparam int FRAME_W     = 8;
    localparam int PA_W        = 16;

    // Page table.
    localparam int PAGE_COUNT  = 256;
    localparam int PT_IDX_W    = $clog2(PAGE_COUNT);

    // TLB.
    localparam int TLB_ENTRIES = 16;
    localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
    localparam int TLB_FILL_W  = $clog2(TLB_ENTRIES + 1);

    // Free frame counter wraps modulo 512.
    localparam int FREE_W      = 9;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Request handed from the front queue to the lookup engine.
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
        logic [OFF_W-1:0]  offset;
    } tlbpt_req_t;

endpackage

// ===== rtl/tlbpt_ram.sv =====
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/tlbpt_front.sv =====
module tlbpt_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [tlbpt_pkg::VA_W-1:0] vaddr,
    output tlbpt_pkg::tlbpt_req_t     req,
    input  logic                      deq
);
    import tlbpt_pkg::*;

    logic [PAGE_W-1:0]      page_q [QUEUE_DEPTH];
    logic [OFF_W-1:0]       off_q  [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   enq;
    logic                   do_deq;

    // The address is split into page number and offset on the way in.
    assign full   = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign enq    = push && !full;
    assign do_deq = deq && (count_reg != '0);

    assign req.valid  = (count_reg != '0);
    assign req.page   = page_q[rd_ptr_reg];
    assign req.offset = off_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = enq    ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !do_deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && do_deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            page_q[wr_ptr_reg] <= vaddr[VA_W-1 -: PAGE_W];
            off_q[wr_ptr_reg]  <= vaddr[OFF_W-1:0];
        end
    end

endmodule

// ===== rtl/tlbpt_back.sv =====
module tlbpt_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlbpt_pkg::tlbpt_req_t         req,
    output logic                          deq,
    output logic                          empty,
    input  logic                          pop,
    output logic [tlbpt_pkg::PAGE_W-1:0]  page_number,
    output logic [tlbpt_pkg::OFF_W-1:0]   page_offset,
    output logic [tlbpt_pkg::FRAME_W-1:0] frame_number,
    output logic [tlbpt_pkg::PA_W-1:0]    paddr,
    output logic                          tlb_hit,
    output logic                          page_fault
);
    import tlbpt_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t                state_reg, state_next;
    logic [PAGE_W-1:0]     page_reg;
    logic [OFF_W-1:0]      offset_reg;

    logic                  out_valid_reg;
    logic [PAGE_W-1:0]     page_number_reg;
    logic [OFF_W-1:0]      page_offset_reg;
    logic [FRAME_W-1:0]    frame_number_reg;
    logic [PA_W-1:0]       paddr_reg;
    logic                  tlb_hit_reg;
    logic                  page_fault_reg;

    logic [PAGE_W-1:0]     tlb_tags   [TLB_ENTRIES];
    logic [FRAME_W-1:0]    tlb_frames [TLB_ENTRIES];
    logic [TLB_FILL_W-1:0] tlb_fill_reg;
    logic [TLB_IDX_W-1:0]  tlb_oldest_reg;
    logic [PAGE_COUNT-1:0] page_valid_reg;
    logic [FREE_W-1:0]     free_frame_reg;

    logic                  ram_re;
    logic                  ram_we;
    logic [FRAME_W-1:0]    ram_rdata;

    logic [TLB_ENTRIES-1:0] match;
    logic                   hit;
    logic [TLB_IDX_W-1:0]   hit_slot;
    logic                   pt_valid;
    logic                   fault;
    logic [FRAME_W-1:0]     frame;
    logic                   can_load;
    logic                   commit;
    logic [TLB_IDX_W-1:0]   ins_slot;

    // Page table frames: written on a fault, read when a request is dequeued, ahead of the lookup.
    tlbpt_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(PAGE_COUNT)
    ) u_page_frames (
        .clk  (clk),
        .we   (ram_we),
        .waddr(page_reg),
        .wdata(frame),
        .re   (ram_re),
        .raddr(req.page),
        .rdata(ram_rdata)
    );

    // An entry takes part in the search only when it lies in the occupied ring.
    always_comb
    begin
        logic [TLB_IDX_W-1:0] ring_pos;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            ring_pos = TLB_IDX_W'(i) - tlb_oldest_reg;
            match[i] = ({1'b0, ring_pos} < tlb_fill_reg) && (tlb_tags[i] == page_reg);
        end
    end

    always_comb
    begin
        hit_slot = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_slot = TLB_IDX_W'(i);
            end
        end
    end

    assign hit      = |match;
    assign pt_valid = page_valid_reg[page_reg];
    assign fault    = !hit && !pt_valid;

    always_comb
    begin
        if (hit)
        begin
            frame = tlb_frames[hit_slot];
        end
        else if (pt_valid)
        begin
            frame = ram_rdata;
        end
        else
        begin
            frame = free_frame_reg[FRAME_W-1:0];
        end
    end

    assign can_load = !out_valid_reg || pop;
    assign commit   = (state_reg == ST_LOOK) && can_load;
    assign deq      = (state_reg == ST_IDLE) && req.valid;
    assign ram_re   = deq;
    assign ram_we   = commit && fault;

    // New TLB entry goes at the end of the ring, or over the oldest when full.
    assign ins_slot = (tlb_fill_reg < TLB_FILL_W'(TLB_ENTRIES))
                    ? tlb_oldest_reg + tlb_fill_reg[TLB_IDX_W-1:0]
                    : tlb_oldest_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            tlb_fill_reg     <= '0;
            tlb_oldest_reg   <= '0;
            page_valid_reg   <= '0;
            free_frame_reg   <= '0;
            page_reg         <= '0;
            offset_reg       <= '0;
            page_number_reg  <= '0;
            page_offset_reg  <= '0;
            frame_number_reg <= '0;
            paddr_reg        <= '0;
            tlb_hit_reg      <= 1'b0;
            page_fault_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (deq)
            begin
                page_reg   <= req.page;
                offset_reg <= req.offset;
            end
            if (commit)
            begin
                page_number_reg  <= page_reg;
                page_offset_reg  <= offset_reg;
                frame_number_reg <= frame;
                paddr_reg        <= {frame, offset_reg};
                tlb_hit_reg      <= hit;
                page_fault_reg   <= fault;
            end
            if (commit && !hit)
            begin
                if (tlb_fill_reg < TLB_FILL_W'(TLB_ENTRIES))
                begin
                    tlb_fill_reg <= tlb_fill_reg + 1'b1;
                end
                else
                begin
                    tlb_oldest_reg <= tlb_oldest_reg + 1'b1;
                end
            end
            if (commit && fault)
            begin
                page_valid_reg[page_reg] <= 1'b1;
                free_frame_reg           <= free_frame_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && !hit)
        begin
            tlb_tags[ins_slot]   <= page_reg;
            tlb_frames[ins_slot] <= frame;
        end
    end

    assign empty        = !out_valid_reg;
    assign page_number  = page_number_reg;
    assign page_offset  = page_offset_reg;
    assign frame_number = frame_number_reg;
    assign paddr        = paddr_reg;
    assign tlb_hit      = tlb_hit_reg;
    assign page_fault   = page_fault_reg;

endmodule

// ===== rtl/tlb_page_table_translation.sv =====
// Channel   Handshake            Beat payload
// -------   ------------------   ----------------------------------------------
// input     push / full          vaddr
// result    empty / pop          page_number, page_offset, frame_number,
//                                paddr, tlb_hit, page_fault
//
// In the lookup engine each beat first reads the page-table frame RAM, then
// searches the TLB, picks the frame and updates all state; while a result is
// held, a low pop stalls the engine. A four-entry address queue in front lets
// input beats arrive while the engine is busy; full rises only when that queue
// holds four addresses. Reset (asynchronous, active low) empties both queues
// and clears TLB fill, page-table valid bits and the free frame count.
module tlb_page_table_translation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tlbpt_pkg::VA_W-1:0]    vaddr,
    output logic                          empty,
    input  logic                          pop,
    output logic [tlbpt_pkg::PAGE_W-1:0]  page_number,
    output logic [tlbpt_pkg::OFF_W-1:0]   page_offset,
    output logic [tlbpt_pkg::FRAME_W-1:0] frame_number,
    output logic [tlbpt_pkg::PA_W-1:0]    paddr,
    output logic                          tlb_hit,
    output logic                          page_fault
);
    import tlbpt_pkg::*;

    // Request from the front queue, and the dequeue strobe back to it.
    tlbpt_req_t req;
    logic       deq;

    // The front accepts addresses and splits them into page and offset.
    tlbpt_front u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .full (full),
        .vaddr(vaddr),
        .req  (req),
        .deq  (deq)
    );

    // The back runs the TLB search, the page-table access and demand paging,
    // then holds the finished beat in its result register until it is popped.
    tlbpt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .deq         (deq),
        .empty       (empty),
        .pop         (pop),
        .page_number (page_number),
        .page_offset (page_offset),
        .frame_number(frame_number),
        .paddr       (paddr),
        .tlb_hit     (tlb_hit),
        .page_fault  (page_fault)
    );

endmodule
